### hdl/thompson_nfa_builder_core_assert.svh
`ifndef THOMPSON_NFA_BUILDER_CORE_ASSERT_SVH
`define THOMPSON_NFA_BUILDER_CORE_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define TNB_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("tnb assertion failed");

// next-cycle implication
`define TNB_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("tnb assertion failed");

`endif

### hdl/tnb_pkg.sv
package tnb_pkg;

	localparam int unsigned NODE_FW = 9;
	localparam int unsigned EDGE_FW = 12;

	localparam logic [1:0] KIND_EDGE    = 2'd0;
	localparam logic [1:0] KIND_SUMMARY = 2'd1;
	localparam logic [1:0] KIND_ERROR   = 2'd2;

	localparam logic       CMD_FINISH = 1'b1;

	localparam logic [7:0] SYM_A     = 8'h61;
	localparam logic [7:0] SYM_Z     = 8'h7a;
	localparam logic [7:0] SYM_DOT   = 8'h2e;
	localparam logic [7:0] SYM_PLUS  = 8'h2b;
	localparam logic [7:0] SYM_STAR  = 8'h2a;
	localparam logic [7:0] EPS_LABEL = 8'h45;

	localparam logic [EDGE_FW-1:0] EDGE_MAX = 12'hfff;

	typedef struct packed {
		logic                take_prev;
		logic                take_next;
	} cell_ctrl_t;

	typedef struct packed {
		logic [1:0]          kind;
		logic [NODE_FW-1:0]  from_node;
		logic [NODE_FW-1:0]  to_node;
		logic                is_epsilon;
		logic [7:0]          label;
		logic [NODE_FW-1:0]  node_count;
		logic [EDGE_FW-1:0]  edge_count;
		logic [NODE_FW-1:0]  accept_node;
		logic                last;
	} res_t;

	function automatic res_t mk_edge(logic [NODE_FW-1:0] from_n, logic [NODE_FW-1:0] to_n,
			logic eps, logic [7:0] lbl, logic lst);
		res_t r;
		r            = '0;
		r.kind       = KIND_EDGE;
		r.from_node  = from_n;
		r.to_node    = to_n;
		r.is_epsilon = eps;
		r.label      = eps ? EPS_LABEL : lbl;
		r.last       = lst;
		return r;
	endfunction

	function automatic res_t mk_error();
		res_t r;
		r      = '0;
		r.kind = KIND_ERROR;
		r.last = 1'b1;
		return r;
	endfunction

	function automatic logic [EDGE_FW-1:0] edge_sat(logic [EDGE_FW-1:0] e, logic [2:0] n);
		logic [EDGE_FW:0] s;
		s = {1'b0, e} + (EDGE_FW+1)'(n);
		return (s > (EDGE_FW+1)'(EDGE_MAX)) ? EDGE_MAX : s[EDGE_FW-1:0];
	endfunction

endpackage

### hdl/tnb_in_if.sv
interface tnb_in_if;
	logic       valid;
	logic       ready;
	logic       cmd;
	logic [7:0] symbol;

	modport source (output valid, output cmd, output symbol, input ready);
	modport sink (input valid, input cmd, input symbol, output ready);
endinterface

### hdl/tnb_out_if.sv
interface tnb_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [8:0]  from_node;
	logic [8:0]  to_node;
	logic        is_epsilon;
	logic [7:0]  label;
	logic [8:0]  node_count;
	logic [11:0] edge_count;
	logic [8:0]  accept_node;
	logic        last;

	modport source (output valid, output kind, output from_node, output to_node,
		output is_epsilon, output label, output node_count, output edge_count,
		output accept_node, output last, input ready);
	modport sink (input valid, input kind, input from_node, input to_node,
		input is_epsilon, input label, input node_count, input edge_count,
		input accept_node, input last, output ready);
endinterface

### hdl/tnb_cell.sv
module tnb_cell #(
	parameter int unsigned W = 18
) (
	input  logic               clk,
	input  tnb_pkg::cell_ctrl_t ctrl,
	input  logic [W-1:0]       prev,
	input  logic [W-1:0]       next,
	output logic [W-1:0]       frag
);
	import tnb_pkg::*;

	logic [W-1:0] frag_q;

	// one stack entry {start, end}; push shifts away from the head, pop toward it
	always_ff @(posedge clk) begin
		if (ctrl.take_prev) begin
			frag_q <= prev;
		end else if (ctrl.take_next) begin
			frag_q <= next;
		end
	end

	assign frag = frag_q;
endmodule

### hdl/thompson_nfa_builder_core.sv
// Thompson NFA builder: one postfix symbol per request, edges out one per cycle while results.ready holds.
// Latency: the first result of a request is valid the cycle after it is accepted.
// Flow: a request yields 0 to 4 results, 4 for a union; the next request is taken in the
// cycle its last result is taken, or at once when no result is pending.
// Reset: stack depth, node and edge counters and the pending-result count clear at once;
// the fragment cells and result slots keep what they held and are only read once written.
module thompson_nfa_builder_core #(
	parameter int unsigned STACK_DEPTH = 32,
	parameter int unsigned MAX_NODES   = 512
) (
	input  logic       clk,
	input  logic       arst_n,
	tnb_in_if.sink     symbols,
	tnb_out_if.source  results
);
	import tnb_pkg::*;

	localparam int unsigned NW = $clog2(MAX_NODES);
	localparam int unsigned CW = $clog2(STACK_DEPTH + 1);
	localparam int unsigned FW = 2 * NW;

	logic [CW-1:0]      cnt_q, cnt_d;
	logic [NW-1:0]      node_q, node_d;
	logic [EDGE_FW-1:0] edge_q;
	logic [2:0]         edge_add;
	logic               clear;

	logic [2:0]         pend_q, n_res;
	logic [1:0]         pos_q;
	res_t               slot_q [4];
	res_t               slot_d [4];
	res_t               cur;

	logic               in_fire, out_fire;
	logic [FW-1:0]      frag_w [STACK_DEPTH];
	logic [FW-1:0]      load_frag;
	cell_ctrl_t         ctl_head, ctl_body, head_sel, body_sel;

	logic [NW-1:0]      t_start, t_end, u_start, u_end, node_a, node_b;
	logic               fits;

	assign t_start = frag_w[0][FW-1:NW];
	assign t_end   = frag_w[0][NW-1:0];
	assign u_start = frag_w[1][FW-1:NW];
	assign u_end   = frag_w[1][NW-1:0];
	assign node_a  = node_q + NW'(1);
	assign node_b  = node_q + NW'(2);
	assign fits    = ({2'b00, node_q} + (NW+2)'(4)) <= (NW+2)'(MAX_NODES);

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			slot_d[i] = '0;
		end
		n_res     = '0;
		cnt_d     = cnt_q;
		node_d    = node_q;
		edge_add  = '0;
		clear     = 1'b0;
		head_sel  = '0;
		body_sel  = '0;
		load_frag = frag_w[0];
		if (symbols.cmd == CMD_FINISH) begin
			clear = 1'b1;
			if (cnt_q == '0) begin
				slot_d[0] = mk_error();
				n_res     = 3'd1;
			end else begin
				slot_d[0]             = mk_edge('0, NODE_FW'(t_start), 1'b1, 8'h00, 1'b0);
				slot_d[1]             = '0;
				slot_d[1].kind        = KIND_SUMMARY;
				slot_d[1].node_count  = NODE_FW'(node_a);
				slot_d[1].edge_count  = edge_sat(edge_q, 3'd1);
				slot_d[1].accept_node = NODE_FW'(t_end);
				slot_d[1].last        = 1'b1;
				n_res                 = 3'd2;
			end
		end else if (symbols.symbol >= SYM_A && symbols.symbol <= SYM_Z) begin
			if (cnt_q >= CW'(STACK_DEPTH) || !fits) begin
				slot_d[0] = mk_error();
				n_res     = 3'd1;
			end else begin
				slot_d[0] = mk_edge(NODE_FW'(node_a), NODE_FW'(node_b), 1'b0,
					symbols.symbol, 1'b1);
				n_res              = 3'd1;
				edge_add           = 3'd1;
				cnt_d              = cnt_q + CW'(1);
				node_d             = node_b;
				load_frag          = {node_a, node_b};
				head_sel.take_prev = 1'b1;
				body_sel.take_prev = 1'b1;
			end
		end else if (symbols.symbol == SYM_DOT) begin
			if (cnt_q < CW'(2)) begin
				slot_d[0] = mk_error();
				n_res     = 3'd1;
			end else begin
				slot_d[0] = mk_edge(NODE_FW'(u_end), NODE_FW'(t_start), 1'b1, 8'h00, 1'b1);
				n_res              = 3'd1;
				edge_add           = 3'd1;
				cnt_d              = cnt_q - CW'(1);
				load_frag          = {u_start, t_end};
				head_sel.take_prev = 1'b1;
				body_sel.take_next = 1'b1;
			end
		end else if (symbols.symbol == SYM_PLUS) begin
			if (cnt_q < CW'(2) || !fits) begin
				slot_d[0] = mk_error();
				n_res     = 3'd1;
			end else begin
				slot_d[0] = mk_edge(NODE_FW'(node_a), NODE_FW'(t_start), 1'b1, 8'h00, 1'b0);
				slot_d[1] = mk_edge(NODE_FW'(node_a), NODE_FW'(u_start), 1'b1, 8'h00, 1'b0);
				slot_d[2] = mk_edge(NODE_FW'(t_end), NODE_FW'(node_b), 1'b1, 8'h00, 1'b0);
				slot_d[3] = mk_edge(NODE_FW'(u_end), NODE_FW'(node_b), 1'b1, 8'h00, 1'b1);
				n_res              = 3'd4;
				edge_add           = 3'd4;
				cnt_d              = cnt_q - CW'(1);
				node_d             = node_b;
				load_frag          = {node_a, node_b};
				head_sel.take_prev = 1'b1;
				body_sel.take_next = 1'b1;
			end
		end else if (symbols.symbol == SYM_STAR) begin
			if (cnt_q == '0) begin
				slot_d[0] = mk_error();
				n_res     = 3'd1;
			end else begin
				slot_d[0] = mk_edge(NODE_FW'(t_start), NODE_FW'(t_end), 1'b1, 8'h00, 1'b0);
				slot_d[1] = mk_edge(NODE_FW'(t_end), NODE_FW'(t_start), 1'b1, 8'h00, 1'b1);
				n_res     = 3'd2;
				edge_add  = 3'd2;
			end
		end
	end

	assign ctl_head = in_fire ? head_sel : '0;
	assign ctl_body = in_fire ? body_sel : '0;

	for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
		logic [FW-1:0] prev_w, next_w;
		cell_ctrl_t    ctl_w;
		if (i == 0) begin : g_head
			assign prev_w = load_frag;
			assign ctl_w  = ctl_head;
		end else begin : g_body
			assign prev_w = frag_w[i-1];
			assign ctl_w  = ctl_body;
		end
		if (i == STACK_DEPTH - 1) begin : g_tail
			assign next_w = '0;
		end else begin : g_mid
			assign next_w = frag_w[i+1];
		end
		tnb_cell #(.W(FW)) u_cell (
			.clk  (clk),
			.ctrl (ctl_w),
			.prev (prev_w),
			.next (next_w),
			.frag (frag_w[i])
		);
	end

	assign results.valid = pend_q != '0;
	assign out_fire      = results.valid && results.ready;
	assign symbols.ready = (pend_q == '0) || (out_fire && pend_q == 3'd1);
	assign in_fire       = symbols.valid && symbols.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			node_q <= '0;
			edge_q <= '0;
		end else if (in_fire) begin
			if (clear) begin
				cnt_q  <= '0;
				node_q <= '0;
				edge_q <= '0;
			end else begin
				cnt_q  <= cnt_d;
				node_q <= node_d;
				edge_q <= edge_sat(edge_q, edge_add);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
			pos_q  <= '0;
		end else if (in_fire) begin
			pend_q <= n_res;
			pos_q  <= '0;
		end else if (out_fire) begin
			pend_q <= pend_q - 3'd1;
			pos_q  <= pos_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			slot_q <= slot_d;
		end
	end

	assign cur                 = slot_q[pos_q];
	assign results.kind        = cur.kind;
	assign results.from_node   = cur.from_node;
	assign results.to_node     = cur.to_node;
	assign results.is_epsilon  = cur.is_epsilon;
	assign results.label       = cur.label;
	assign results.node_count  = cur.node_count;
	assign results.edge_count  = cur.edge_count;
	assign results.accept_node = cur.accept_node;
	assign results.last        = cur.last;

`include "thompson_nfa_builder_core_assert.svh"

	`TNB_ASSERT_NEXT(a_finish_clears, in_fire && symbols.cmd == CMD_FINISH, cnt_q == '0 && node_q == '0)
	`TNB_ASSERT_NOW(a_last_ends_item, results.valid && results.last, pend_q == 3'd1)
	`TNB_ASSERT_NOW(a_busy_stalls, pend_q > 3'd1, !symbols.ready)
	`TNB_ASSERT_NOW(a_node_bound, 1'b1, {2'b00, node_q} <= (NW+2)'(MAX_NODES - 2))

endmodule

### dv/nfa_result_check.sv
module nfa_result_check #(
	parameter int unsigned STACK_CAP = 32,
	parameter int unsigned NODE_CAP  = 512
) (
	input  logic clk,
	input  logic arst_n,
	tnb_in_if    symbols,
	tnb_out_if   results,
	output int   mismatches,
	output int   pending
);
	import tnb_pkg::*;

	logic [NODE_FW-1:0] frag_head [STACK_CAP];
	logic [NODE_FW-1:0] frag_tail [STACK_CAP];
	int unsigned        depth      = 0;
	int unsigned        nodes_used = 0;
	logic [EDGE_FW-1:0] edges_made = '0;

	res_t step_out [4];
	int   step_n;
	res_t nfa_results_due [$];
	res_t want;
	int   misses = 0;

	assign mismatches = misses;

	task automatic report_mismatch(input string what, input int got, input int want_v);
		$display("mismatch at %0t: %s got %0d, want %0d", $time, what, got, want_v);
		misses++;
	endtask

	task automatic emit_edge(input logic [NODE_FW-1:0] src, input logic [NODE_FW-1:0] dst,
			input logic eps, input logic [7:0] lbl);
		res_t r;
		r            = '0;
		r.kind       = KIND_EDGE;
		r.from_node  = src;
		r.to_node    = dst;
		r.is_epsilon = eps;
		r.label      = eps ? EPS_LABEL : lbl;
		step_out[step_n] = r;
		step_n++;
		if (edges_made != EDGE_MAX) begin
			edges_made++;
		end
	endtask

	task automatic emit_fault();
		res_t r;
		r           = '0;
		r.kind      = KIND_ERROR;
		step_out[0] = r;
		step_n      = 1;
	endtask

	// one request through the Thompson construction; fills nfa_results_due
	task automatic thompson_step(input logic c, input logic [7:0] s);
		int unsigned        t;
		int unsigned        u;
		logic [NODE_FW-1:0] fresh_a;
		logic [NODE_FW-1:0] fresh_b;
		bit                 room;
		res_t               tally;
		step_n  = 0;
		t       = depth - 1;
		u       = depth - 2;
		fresh_a = NODE_FW'(nodes_used + 1);
		fresh_b = NODE_FW'(nodes_used + 2);
		room    = (nodes_used + 2 <= NODE_CAP - 2);
		if (c == CMD_FINISH) begin
			if (depth == 0) begin
				emit_fault();
			end else begin
				emit_edge('0, frag_head[t], 1'b1, '0);
				tally             = '0;
				tally.kind        = KIND_SUMMARY;
				tally.node_count  = NODE_FW'(nodes_used + 1);
				tally.edge_count  = edges_made;
				tally.accept_node = frag_tail[t];
				step_out[step_n]  = tally;
				step_n++;
			end
			depth      = 0;
			nodes_used = 0;
			edges_made = '0;
		end else if (s >= SYM_A && s <= SYM_Z) begin
			if (depth >= STACK_CAP || !room) begin
				emit_fault();
			end else begin
				emit_edge(fresh_a, fresh_b, 1'b0, s);
				frag_head[depth] = fresh_a;
				frag_tail[depth] = fresh_b;
				depth++;
				nodes_used += 2;
			end
		end else if (s == SYM_DOT) begin
			if (depth < 2) begin
				emit_fault();
			end else begin
				emit_edge(frag_tail[u], frag_head[t], 1'b1, '0);
				frag_tail[u] = frag_tail[t];
				depth--;
			end
		end else if (s == SYM_PLUS) begin
			if (depth < 2 || !room) begin
				emit_fault();
			end else begin
				emit_edge(fresh_a, frag_head[t], 1'b1, '0);
				emit_edge(fresh_a, frag_head[u], 1'b1, '0);
				emit_edge(frag_tail[t], fresh_b, 1'b1, '0);
				emit_edge(frag_tail[u], fresh_b, 1'b1, '0);
				frag_head[u] = fresh_a;
				frag_tail[u] = fresh_b;
				depth--;
				nodes_used += 2;
			end
		end else if (s == SYM_STAR) begin
			if (depth < 1) begin
				emit_fault();
			end else begin
				emit_edge(frag_head[t], frag_tail[t], 1'b1, '0);
				emit_edge(frag_tail[t], frag_head[t], 1'b1, '0);
			end
		end
		if (step_n > 0) begin
			step_out[step_n-1].last = 1'b1;
		end
		for (int i = 0; i < step_n; i++) begin
			nfa_results_due.insert(nfa_results_due.size(), step_out[i]);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth      = 0;
			nodes_used = 0;
			edges_made = '0;
			nfa_results_due.delete();
			pending <= 0;
		end else begin
			if (symbols.valid && symbols.ready) begin
				thompson_step(symbols.cmd, symbols.symbol);
			end
			if (results.valid && results.ready) begin
				if (nfa_results_due.size() == 0) begin
					report_mismatch("result with nothing pending, kind", results.kind, -1);
				end else begin
					want = nfa_results_due[0];
					nfa_results_due.delete(0);
					if (results.kind !== want.kind)
						report_mismatch("kind", results.kind, want.kind);
					if (results.from_node !== want.from_node)
						report_mismatch("from_node", results.from_node, want.from_node);
					if (results.to_node !== want.to_node)
						report_mismatch("to_node", results.to_node, want.to_node);
					if (results.is_epsilon !== want.is_epsilon)
						report_mismatch("is_epsilon", results.is_epsilon, want.is_epsilon);
					if (results.label !== want.label)
						report_mismatch("label", results.label, want.label);
					if (results.node_count !== want.node_count)
						report_mismatch("node_count", results.node_count, want.node_count);
					if (results.edge_count !== want.edge_count)
						report_mismatch("edge_count", results.edge_count, want.edge_count);
					if (results.accept_node !== want.accept_node)
						report_mismatch("accept_node", results.accept_node, want.accept_node);
					if (results.last !== want.last)
						report_mismatch("last", results.last, want.last);
				end
			end
			pending <= nfa_results_due.size();
		end
	end

endmodule

### dv/tb.sv
module tb;
	import tnb_pkg::*;

	localparam logic CMD_POSTFIX     = 1'b0;
	localparam int   STACK_CAP       = 32;
	localparam int   NODE_CAP        = 512;
	localparam int   RESET_CYCLES    = 12;
	localparam int   HOLD_OFF_CYCLES = 64;
	localparam int   DRAIN_CYCLES    = 8;
	localparam int   WATCHDOG_LIMIT  = 1000;

	logic clk;
	logic arst_n;
	int   mismatches;
	int   pending;
	int   sent;
	int   target;
	bit   no_gaps;
	bit   tail_part;
	bit   hold_request;

	tnb_in_if  symbols();
	tnb_out_if results();

	thompson_nfa_builder_core #(
		.STACK_DEPTH(STACK_CAP),
		.MAX_NODES  (NODE_CAP)
	) u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.symbols(symbols),
		.results(results)
	);

	nfa_result_check #(
		.STACK_CAP(STACK_CAP),
		.NODE_CAP (NODE_CAP)
	) u_check (
		.clk       (clk),
		.arst_n    (arst_n),
		.symbols   (symbols),
		.results   (results),
		.mismatches(mismatches),
		.pending   (pending)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	task automatic send_request(input logic c, input logic [7:0] s);
		if (!no_gaps && $urandom_range(0, 3) == 0) begin
			symbols.valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		symbols.valid  <= 1'b1;
		symbols.cmd    <= c;
		symbols.symbol <= s;
		@(posedge clk);
		while (!symbols.ready) @(posedge clk);
		sent++;
		if (!tail_part && $urandom_range(0, 39) == 0) begin
			no_gaps = !no_gaps;
		end
	endtask

	function automatic logic [7:0] any_letter();
		return SYM_A + 8'($urandom_range(0, 25));
	endfunction

	task automatic finish_expr();
		send_request(CMD_FINISH, 8'($urandom));
	endtask

	// mostly well-formed postfix with random content; noise may break it
	task automatic random_expression(input int letters);
		int open;
		int left;
		open = 0;
		left = letters;
		while (left > 0 || open > 1) begin
			if ($urandom_range(0, 29) == 0) begin
				break;
			end else if ($urandom_range(0, 9) == 0) begin
				send_request(1'($urandom_range(0, 5) == 0), 8'($urandom));
			end else if (open > 0 && $urandom_range(0, 5) == 0) begin
				send_request(CMD_POSTFIX, SYM_STAR);
			end else if (left > 0 && (open < 2 || $urandom_range(0, 1) == 0)) begin
				send_request(CMD_POSTFIX, any_letter());
				open++;
				left--;
			end else begin
				send_request(CMD_POSTFIX, $urandom_range(0, 1) ? SYM_DOT : SYM_PLUS);
				open--;
			end
		end
		finish_expr();
	endtask

	task automatic stack_overflow_run();
		repeat (STACK_CAP + 2) send_request(CMD_POSTFIX, any_letter());
		repeat (STACK_CAP - 1) send_request(CMD_POSTFIX,
			$urandom_range(0, 1) ? SYM_DOT : SYM_PLUS);
		finish_expr();
	endtask

	initial begin
		arst_n         = 1'b0;
		symbols.valid  = 1'b0;
		symbols.cmd    = CMD_POSTFIX;
		symbols.symbol = '0;
		no_gaps        = 1'b0;
		tail_part      = 1'b0;
		hold_request   = 1'b0;
		sent           = 0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		send_request(CMD_FINISH, 8'h00);
		send_request(CMD_POSTFIX, SYM_DOT);
		send_request(CMD_POSTFIX, SYM_STAR);
		send_request(CMD_POSTFIX, SYM_PLUS);
		send_request(CMD_POSTFIX, 8'h00);
		send_request(CMD_POSTFIX, SYM_A);
		send_request(CMD_POSTFIX, SYM_PLUS);
		send_request(CMD_POSTFIX, SYM_DOT);
		send_request(CMD_POSTFIX, 8'hff);
		send_request(CMD_POSTFIX, SYM_STAR);
		send_request(CMD_POSTFIX, SYM_Z);
		send_request(CMD_POSTFIX, SYM_DOT);
		send_request(CMD_POSTFIX, 8'h60);
		send_request(CMD_POSTFIX, 8'h7b);
		send_request(CMD_POSTFIX, SYM_A + 8'd12);
		send_request(CMD_POSTFIX, SYM_PLUS);
		send_request(CMD_POSTFIX, SYM_STAR);
		send_request(CMD_FINISH, 8'hff);
		send_request(CMD_POSTFIX, SYM_A + 8'd1);
		send_request(CMD_POSTFIX, SYM_A + 8'd2);
		send_request(CMD_FINISH, SYM_DOT);

		hold_request = 1'b1;
		target = sent + 70;
		while (sent < target) random_expression($urandom_range(1, 10));
		stack_overflow_run();
		target = sent + 70;
		while (sent < target) random_expression($urandom_range(1, 10));

		tail_part = 1'b1;
		no_gaps   = 1'b1;
		target = sent + 30;
		while (sent < target) random_expression($urandom_range(1, 10));

		symbols.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

	initial begin
		results.ready = 1'b0;
		repeat (RESET_CYCLES) @(posedge clk);
		forever begin
			if (hold_request) begin
				hold_request = 1'b0;
				results.ready <= 1'b0;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
			end else if (!no_gaps && $urandom_range(0, 4) == 0) begin
				results.ready <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end else begin
				results.ready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	initial begin
		int stuck;
		stuck = 0;
		while (stuck < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((symbols.valid && symbols.ready) || (results.valid && results.ready)) begin
				stuck = 0;
			end else begin
				stuck++;
			end
		end
		$display("CHECK FAILED");
		$finish;
	end

endmodule

### sim.f
+incdir+hdl
hdl/tnb_pkg.sv
hdl/tnb_in_if.sv
hdl/tnb_out_if.sv
hdl/tnb_cell.sv
hdl/thompson_nfa_builder_core.sv
dv/nfa_result_check.sv
dv/tb.sv
